// ===== rtl/brs_pkg.sv =====
// Shared types and constants for the block range sum engine.
// Item and result payloads, controller/datapath command and status groups.
`default_nettype none

package brs_pkg;

  localparam int POS_W = 10;
  localparam int VAL_W = 32;
  localparam int SUM_W = 64;

  localparam int DEF_ELEMENTS   = 1024;
  localparam int DEF_BLOCK_SIZE = 32;

  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  typedef struct packed {
    logic                    operation;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] new_value;
    logic [POS_W-1:0]        range_left;
    logic [POS_W-1:0]        range_right;
  } brs_item_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] range_total;
    logic                    range_error;
  } brs_result_t;

  typedef struct packed {
    logic clr_step;
    logic latch;
    logic div_mul;
    logic div_rem;
    logic div_fix;
    logic u_read;
    logic u_diff;
    logic u_write;
    logic q_step;
    logic out_load;
  } brs_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic is_query;
    logic pos_ok;
    logic rev;
    logic q_more;
    logic pend;
  } brs_sts_t;

  function automatic logic [SUM_W-1:0] widen(input logic [VAL_W-1:0] v);
    return {{(SUM_W - VAL_W){v[VAL_W-1]}}, v};
  endfunction

endpackage

`default_nettype wire

// ===== rtl/brs_in_if.sv =====
// Request channel: valid/ready handshake carrying one update or query item.
// Depends on brs_pkg for the item payload type.
`default_nettype none

interface brs_in_if import brs_pkg::*; ();
  logic      valid;
  logic      ready;
  brs_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/brs_out_if.sv =====
// Response channel: valid/ready handshake carrying one range sum result.
// Depends on brs_pkg for the result payload type.
`default_nettype none

interface brs_out_if import brs_pkg::*; ();
  logic        valid;
  logic        ready;
  brs_result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/brs_datapath.sv =====
// Datapath: element and block sum memories, reciprocal block divider,
// query walk counters, accumulator and result register. Uses brs_pkg.
`default_nettype none

module brs_datapath import brs_pkg::*; #(
  parameter int ELEMENTS   = DEF_ELEMENTS,
  parameter int BLOCK_SIZE = DEF_BLOCK_SIZE
) (
  input  logic        clk,
  input  logic        rst,
  input  brs_cmd_t    cmd,
  output brs_sts_t    sts,
  input  brs_item_t   req_data,
  output brs_result_t rsp_data
);

  localparam int AW    = $clog2(ELEMENTS);
  localparam int BC    = (ELEMENTS + BLOCK_SIZE - 1) / BLOCK_SIZE;
  localparam int BW    = (BC > 1) ? $clog2(BC) : 1;
  localparam int IW    = ((AW > POS_W) ? AW : POS_W) + 2;
  localparam int OW    = $clog2(BLOCK_SIZE);
  localparam int RECIP = (2 ** POS_W) / BLOCK_SIZE;
  localparam int RW    = $clog2(RECIP + 1);
  localparam int PW    = POS_W + RW;

  logic [VAL_W-1:0] elem_mem [ELEMENTS];
  logic [SUM_W-1:0] bsum_mem [BC];

  logic             is_query;
  logic [POS_W-1:0] pos;
  logic [VAL_W-1:0] val;
  logic [POS_W-1:0] left;
  logic [IW-1:0]    right_c;
  logic             rev;
  logic [AW:0]      clr;
  logic [PW-1:0]    prod;
  logic [RW-1:0]    q0;
  logic [IW-1:0]    r0;
  logic [IW-1:0]    i;
  logic [IW-1:0]    blk;
  logic [OW-1:0]    off;
  logic [VAL_W-1:0] elem_rd;
  logic [SUM_W-1:0] bsum_rd;
  logic             pend;
  logic             pend_blk;
  logic [SUM_W-1:0] diff;
  logic [SUM_W-1:0] acc;
  logic [SUM_W-1:0] out_total;
  logic             out_error;

  logic [POS_W-1:0] div_x;
  logic [IW-1:0]    pos_ext;
  logic [IW-1:0]    right_ext;
  logic [AW-1:0]    elem_raddr;
  logic             full;

  assign div_x      = is_query ? left : pos;
  assign pos_ext    = IW'(pos);
  assign right_ext  = IW'(req_data.range_right);
  assign full       = (off == '0) && ((i + IW'(BLOCK_SIZE - 1)) <= right_c);
  assign elem_raddr = cmd.q_step ? i[AW-1:0] : pos_ext[AW-1:0];

  always_comb begin
    sts          = '0;
    sts.clr_done = (clr == (AW + 1)'(ELEMENTS));
    sts.is_query = is_query;
    sts.pos_ok   = pos_ext < IW'(ELEMENTS);
    sts.rev      = rev;
    sts.q_more   = i <= right_c;
    sts.pend     = pend;
  end

  assign rsp_data.range_total = out_total;
  assign rsp_data.range_error = out_error;

  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      elem_mem[clr[AW-1:0]] <= '0;
    end else if (cmd.u_write) begin
      elem_mem[pos_ext[AW-1:0]] <= val;
    end
    if (cmd.u_read || (cmd.q_step && !full)) begin
      elem_rd <= elem_mem[elem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_step && (clr < (AW + 1)'(BC))) begin
      bsum_mem[clr[BW-1:0]] <= '0;
    end else if (cmd.u_write) begin
      bsum_mem[blk[BW-1:0]] <= bsum_rd + diff;
    end
    if (cmd.u_read || (cmd.q_step && full)) begin
      bsum_rd <= bsum_mem[blk[BW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr  <= '0;
      pend <= 1'b0;
    end else begin
      if (cmd.clr_step) begin
        clr <= clr + 1'b1;
      end
      pend <= cmd.q_step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      is_query <= req_data.operation;
      pos      <= req_data.position;
      val      <= req_data.new_value;
      left     <= req_data.range_left;
      right_c  <= (right_ext > IW'(ELEMENTS - 1)) ? IW'(ELEMENTS - 1) : right_ext;
      rev      <= req_data.range_left > req_data.range_right;
      acc      <= '0;
    end else if (pend) begin
      acc <= acc + (pend_blk ? bsum_rd : widen(elem_rd));
    end

    if (cmd.div_mul) begin
      prod <= PW'(div_x) * PW'(RECIP);
    end

    if (cmd.div_rem) begin
      q0 <= prod[PW-1:POS_W];
      r0 <= IW'(div_x) - IW'(prod[PW-1:POS_W]) * IW'(BLOCK_SIZE);
    end

    if (cmd.div_fix) begin
      i <= IW'(div_x);
      if (r0 >= IW'(BLOCK_SIZE)) begin
        blk <= IW'(q0) + 1'b1;
        off <= OW'(r0 - IW'(BLOCK_SIZE));
      end else begin
        blk <= IW'(q0);
        off <= r0[OW-1:0];
      end
    end else if (cmd.q_step) begin
      pend_blk <= full;
      if (full) begin
        i   <= i + IW'(BLOCK_SIZE);
        blk <= blk + 1'b1;
      end else begin
        i <= i + 1'b1;
        if (off == OW'(BLOCK_SIZE - 1)) begin
          off <= '0;
          blk <= blk + 1'b1;
        end else begin
          off <= off + 1'b1;
        end
      end
    end

    if (cmd.u_diff) begin
      diff <= widen(val) - widen(elem_rd);
    end

    if (cmd.out_load) begin
      out_total <= acc;
      out_error <= rev;
    end
  end

`ifndef ASSERT_OFF
  a_elem_in_range: assert property (@(posedge clk) disable iff (rst)
    (cmd.q_step && !full) |-> (i < IW'(ELEMENTS)))
    else $error("element read past the end of the store");

  a_block_in_range: assert property (@(posedge clk) disable iff (rst)
    (cmd.q_step && full) |-> (blk < IW'(BC)))
    else $error("block sum read past the last block");

  a_div_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.div_fix |-> (r0 < IW'(2 * BLOCK_SIZE)))
    else $error("block divider remainder needs more than one correction");
`endif

endmodule

`default_nettype wire

// ===== rtl/brs_ctrl.sv =====
// Controller: sequences clearing, updates and query walks over the datapath,
// and owns the request ready and response valid. Uses brs_pkg.
`default_nettype none

module brs_ctrl import brs_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  brs_sts_t sts,
  output brs_cmd_t cmd,
  input  logic     req_valid,
  output logic     req_ready,
  output logic     rsp_valid,
  input  logic     rsp_ready
);

  typedef enum logic [3:0] {
    CLEAR,
    IDLE,
    DIV_MUL,
    DIV_REM,
    DIV_FIX,
    U_READ,
    U_DIFF,
    U_WRITE,
    Q_RUN,
    Q_DONE
  } state_t;

  state_t state;
  state_t state_next;
  logic   slot_free;

  assign slot_free = !rsp_valid || rsp_ready;

  always_comb begin
    cmd        = '0;
    req_ready  = 1'b0;
    state_next = state;
    case (state)
      CLEAR: begin
        cmd.clr_step = !sts.clr_done;
        if (sts.clr_done) begin
          state_next = IDLE;
        end
      end
      IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.latch  = 1'b1;
          state_next = DIV_MUL;
        end
      end
      DIV_MUL: begin
        if (!sts.is_query && !sts.pos_ok) begin
          state_next = IDLE;
        end else if (sts.is_query && sts.rev) begin
          state_next = Q_DONE;
        end else begin
          cmd.div_mul = 1'b1;
          state_next  = DIV_REM;
        end
      end
      DIV_REM: begin
        cmd.div_rem = 1'b1;
        state_next  = DIV_FIX;
      end
      DIV_FIX: begin
        cmd.div_fix = 1'b1;
        state_next  = sts.is_query ? Q_RUN : U_READ;
      end
      U_READ: begin
        cmd.u_read = 1'b1;
        state_next = U_DIFF;
      end
      U_DIFF: begin
        cmd.u_diff = 1'b1;
        state_next = U_WRITE;
      end
      U_WRITE: begin
        cmd.u_write = 1'b1;
        state_next  = IDLE;
      end
      Q_RUN: begin
        if (sts.q_more) begin
          cmd.q_step = 1'b1;
        end else begin
          state_next = Q_DONE;
        end
      end
      Q_DONE: begin
        if (slot_free) begin
          cmd.out_load = 1'b1;
          state_next   = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= CLEAR;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    !sts.clr_done |-> !req_ready)
    else $error("item accepted before the clearing pass finished");

  a_acc_settled: assert property (@(posedge clk) disable iff (rst)
    (state == Q_DONE) |-> !sts.pend)
    else $error("result taken while a read is still being accumulated");

  a_write_valid_update: assert property (@(posedge clk) disable iff (rst)
    (state == U_WRITE) |-> (!sts.is_query && sts.pos_ok))
    else $error("memory write for a query or an out of range position");
`endif

endmodule

`default_nettype wire

// ===== rtl/block_range_sum_point_update.sv =====
// Block range sum with point update: ELEMENTS signed values, one sum per block.
// Update: divide (multiply, remainder, fix), read, difference, write, then ready.
// Query: divide, then a walk of at most 2*(BLOCK_SIZE-1) + ELEMENTS/BLOCK_SIZE
// reads, one memory read a cycle. Reversed range: no walk. Result waits in an
// output register. After rst a clearing pass zeroes both memories, ready low.
`default_nettype none

module block_range_sum_point_update import brs_pkg::*; #(
  parameter int ELEMENTS   = DEF_ELEMENTS,
  parameter int BLOCK_SIZE = DEF_BLOCK_SIZE
) (
  input logic        clk,
  input logic        rst,
  brs_in_if.sink     req,
  brs_out_if.source  rsp
);

  brs_cmd_t cmd;
  brs_sts_t sts;

  brs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .sts       (sts),
    .cmd       (cmd),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready)
  );

  brs_datapath #(
    .ELEMENTS   (ELEMENTS),
    .BLOCK_SIZE (BLOCK_SIZE)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .req_data (req.data),
    .rsp_data (rsp.data)
  );

endmodule

`default_nettype wire
